// ===== hdl/crgh_pkg.sv =====
// Shared types, constants and helpers for the Catmull-Rom grid height lookup.
// No dependencies; every other file imports this package.
package crgh_pkg;

   localparam int MAX_X_POINTS = 64;
   localparam int MAX_Y_POINTS = 64;
   localparam int PT_DEPTH = (MAX_X_POINTS > MAX_Y_POINTS) ? MAX_X_POINTS : MAX_Y_POINTS;
   localparam int PT_IDX_W = $clog2(PT_DEPTH);
   localparam int CNT_W = $clog2(PT_DEPTH + 1);

   localparam int HT_DEPTH = 4096;
   localparam int HT_ADDR_W = 12;

   localparam int Q_W = 32;
   localparam int OFF_W = Q_W + 1;
   localparam int SP_W = 31;
   localparam int FRAC_W = 16;
   localparam int ONE_Q16 = 65536;
   localparam int QB_W = FRAC_W + 2;
   localparam int S_W = 19;
   localparam int S_LIMIT = 3 * ONE_Q16;
   localparam int S2_W = 21;
   localparam int S3_W = 24;
   localparam int WM_W = S2_W + S_W;
   localparam int W_W = 26;
   localparam int P_W = 43;
   localparam int PR_W = W_W + Q_W + 1;
   localparam int ACC_W = 72;
   localparam int ADDR_W = 4;

   typedef enum logic [1:0] {
      OP_WR_X  = 2'd0,
      OP_WR_Y  = 2'd1,
      OP_WR_H  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   localparam logic [1:0] REG_X_COUNT   = 2'd0;
   localparam logic [1:0] REG_Y_COUNT   = 2'd1;
   localparam logic [1:0] REG_X_SPACING = 2'd2;
   localparam logic [1:0] REG_Y_SPACING = 2'd3;

   typedef struct packed {
      op_type                  op;
      logic                    drop;
      logic [HT_ADDR_W-1:0]    index;
      logic signed [Q_W-1:0]   value;
      logic signed [Q_W-1:0]   qx;
      logic signed [Q_W-1:0]   qy;
   } item_type;

   typedef struct packed {
      logic [CNT_W-1:0] xn;
      logic [CNT_W-1:0] yn;
      logic [SP_W-1:0]  x_spacing;
      logic [SP_W-1:0]  y_spacing;
   } cfg_type;

   function automatic logic [CNT_W-1:0] eff_count(logic [6:0] c, int maxc);
      logic [CNT_W-1:0] r;
      if (int'(c) < 2) r = CNT_W'(2);
      else if (int'(c) > maxc) r = CNT_W'(maxc);
      else r = CNT_W'(c);
      return r;
   endfunction

endpackage

// ===== hdl/crgh_if.sv =====
// Request and response channel interfaces of the grid height lookup.
// Depends on crgh_pkg.
interface crgh_req_if import crgh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [1:0]            op;
   logic [HT_ADDR_W-1:0]  index;
   logic signed [Q_W-1:0] value;
   logic signed [Q_W-1:0] query_x;
   logic signed [Q_W-1:0] query_y;
   modport source(output valid, op, index, value, query_x, query_y, input ready);
   modport sink(input valid, op, index, value, query_x, query_y, output ready);
endinterface

interface crgh_rsp_if import crgh_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic signed [Q_W-1:0] height;
   logic                  saturated;
   modport source(output valid, height, saturated, input ready);
   modport sink(input valid, height, saturated, output ready);
endinterface

// ===== hdl/crgh_front.sv =====
// Front end: takes request beats, classifies them and holds them in a two-entry queue.
// Depends on crgh_pkg and crgh_if.
module crgh_front import crgh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   crgh_req_if.sink req,
   output item_type q_item,
   output logic     q_valid,
   input  logic     q_pop
);
   item_type   slot_ff [2];
   logic       wr_ptr_ff, rd_ptr_ff;
   logic [1:0] count_ff;
   item_type   item_in;
   logic       push, pop;

   always_comb begin
      item_in.op    = op_type'(req.op);
      item_in.index = req.index;
      item_in.value = req.value;
      item_in.qx    = req.query_x;
      item_in.qy    = req.query_y;
      unique case (op_type'(req.op))
         OP_WR_X: item_in.drop = int'(req.index) >= MAX_X_POINTS;
         OP_WR_Y: item_in.drop = int'(req.index) >= MAX_Y_POINTS;
         default: item_in.drop = 1'b0;
      endcase
   end

   assign req.ready = count_ff != 2'd2;
   assign push      = req.valid && req.ready;
   assign q_valid   = count_ff != 2'd0;
   assign pop       = q_pop && q_valid;
   assign q_item    = slot_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) slot_ff[wr_ptr_ff] <= item_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (push) wr_ptr_ff <= !wr_ptr_ff;
         if (pop) rd_ptr_ff <= !rd_ptr_ff;
         count_ff <= count_ff + {1'b0, push} - {1'b0, pop};
      end
   end
endmodule

// ===== hdl/crgh_search.sv =====
// Coordinate list memory with a binary search sequencer for one axis.
// Depends on crgh_pkg.
module crgh_search import crgh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  wr_en,
   input  logic [PT_IDX_W-1:0]   wr_addr,
   input  logic signed [Q_W-1:0] wr_data,
   input  logic                  start,
   input  logic [CNT_W-1:0]      count,
   input  logic signed [Q_W-1:0] key,
   output logic                  done,
   output logic [PT_IDX_W-1:0]   idx,
   output logic signed [Q_W-1:0] corner
);
   typedef enum logic [2:0] {SR_IDLE, SR_ISSUE, SR_CMP, SR_HIT, SR_CRD, SR_CDAT} sr_state_type;

   sr_state_type          state_ff;
   logic [PT_IDX_W-1:0]   lo_ff, hi_ff, mid_ff, idx_ff;
   logic signed [Q_W-1:0] corner_ff;
   logic                  done_ff;
   logic signed [Q_W-1:0] mem [PT_DEPTH];
   logic signed [Q_W-1:0] rd_data_ff;
   logic [PT_IDX_W-1:0]   rd_addr, last;
   logic                  wide;

   assign last = PT_IDX_W'(count - CNT_W'(1));
   assign wide = (hi_ff - lo_ff) > PT_IDX_W'(1);

   always_comb begin
      if (state_ff == SR_ISSUE) rd_addr = wide ? mid_ff : hi_ff;
      else rd_addr = idx_ff;
   end

   always_ff @(posedge clock) begin
      if (wr_en) mem[wr_addr] <= wr_data;
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= SR_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            SR_IDLE: begin
               if (start) begin
                  lo_ff    <= '0;
                  hi_ff    <= last;
                  mid_ff   <= last >> 1;
                  state_ff <= SR_ISSUE;
               end
            end
            SR_ISSUE: begin
               state_ff <= wide ? SR_CMP : SR_HIT;
            end
            SR_CMP: begin
               if (rd_data_ff == key) begin
                  idx_ff   <= mid_ff;
                  state_ff <= SR_CRD;
               end else if (rd_data_ff < key) begin
                  lo_ff    <= mid_ff;
                  mid_ff   <= mid_ff + ((hi_ff - mid_ff) >> 1);
                  state_ff <= SR_ISSUE;
               end else begin
                  hi_ff    <= mid_ff;
                  mid_ff   <= lo_ff + ((mid_ff - lo_ff) >> 1);
                  state_ff <= SR_ISSUE;
               end
            end
            SR_HIT: begin
               idx_ff   <= (rd_data_ff == key) ? hi_ff : lo_ff;
               state_ff <= SR_CRD;
            end
            SR_CRD: begin
               state_ff <= SR_CDAT;
            end
            SR_CDAT: begin
               corner_ff <= rd_data_ff;
               done_ff   <= 1'b1;
               state_ff  <= SR_IDLE;
            end
            default: state_ff <= SR_IDLE;
         endcase
      end
   end

   assign done   = done_ff;
   assign idx    = idx_ff;
   assign corner = corner_ff;
endmodule

// ===== hdl/crgh_div.sv =====
// Radix-2 restoring divider forming the saturated spline parameter from an offset.
// Depends on crgh_pkg.
module crgh_div import crgh_pkg::*; (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    start,
   input  logic signed [OFF_W-1:0] offset,
   input  logic [SP_W-1:0]         spacing,
   output logic                    done,
   output logic signed [S_W-1:0]   quot
);
   typedef enum logic [1:0] {DV_IDLE, DV_RUN, DV_FIN} dv_state_type;

   dv_state_type                state_ff;
   logic [SP_W-1:0]             rem_ff;
   logic [QB_W-1:0]             bits_ff, q_ff, q_lim;
   logic [$clog2(QB_W+1)-1:0]   cnt_ff;
   logic                        neg_ff, done_ff;
   logic signed [S_W-1:0]       quot_ff;
   logic [OFF_W-1:0]            mag;
   logic [SP_W:0]               trial;
   logic                        ge;

   assign mag   = offset[OFF_W-1] ? $unsigned(-offset) : $unsigned(offset);
   assign trial = {rem_ff, bits_ff[QB_W-1]};
   assign ge    = trial >= {1'b0, spacing};
   assign q_lim = (q_ff > QB_W'(S_LIMIT)) ? QB_W'(S_LIMIT) : q_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= DV_IDLE;
         done_ff  <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            DV_IDLE: begin
               if (start) begin
                  neg_ff <= offset[OFF_W-1];
                  if (mag >= {spacing, 2'b00}) begin
                     q_ff     <= QB_W'(S_LIMIT);
                     state_ff <= DV_FIN;
                  end else begin
                     rem_ff   <= mag[OFF_W-1:2];
                     bits_ff  <= {mag[1:0], {FRAC_W{1'b0}}};
                     q_ff     <= '0;
                     cnt_ff   <= ($clog2(QB_W+1))'(QB_W);
                     state_ff <= DV_RUN;
                  end
               end
            end
            DV_RUN: begin
               rem_ff  <= ge ? SP_W'(trial - {1'b0, spacing}) : SP_W'(trial);
               q_ff    <= {q_ff[QB_W-2:0], ge};
               bits_ff <= bits_ff << 1;
               cnt_ff  <= cnt_ff - 1'b1;
               if (cnt_ff == ($clog2(QB_W+1))'(1)) state_ff <= DV_FIN;
            end
            DV_FIN: begin
               quot_ff  <= neg_ff ? -signed'({1'b0, q_lim}) : signed'({1'b0, q_lim});
               done_ff  <= 1'b1;
               state_ff <= DV_IDLE;
            end
            default: state_ff <= DV_IDLE;
         endcase
      end
   end

   assign done = done_ff;
   assign quot = quot_ff;
endmodule

// ===== hdl/crgh_back.sv =====
// Back end: executes queued beats - table writes, searches, divisions and the spline passes.
// Depends on crgh_pkg, crgh_if, crgh_search and crgh_div.
module crgh_back import crgh_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  cfg_type  cfg,
   input  item_type q_item,
   input  logic     q_valid,
   output logic     q_pop,
   crgh_rsp_if.source rsp
);
   typedef enum logic [3:0] {
      ST_IDLE, ST_SRCH, ST_DIV, ST_WSQ, ST_WCU, ST_WFIN,
      ST_RD, ST_MLO, ST_MHI, ST_ACC, ST_OUT
   } st_type;

   st_type                 state_ff;
   logic signed [Q_W-1:0]  qx_ff, qy_ff;
   logic                   xs_fin_ff, ys_fin_ff, xd_fin_ff, yd_fin_ff;
   logic signed [S_W-1:0]  s_ff, t_ff;
   logic                   axis_ff, pass_ff;
   logic signed [WM_W-1:0] wm_ff;
   logic signed [S2_W-1:0] s2_ff;
   logic signed [W_W-1:0]  w_ff [2][4];
   logic [1:0]             ix_ff, iy_ff;
   logic signed [P_W-1:0]  rows_ff [4];
   logic signed [PR_W-1:0] prod_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic signed [Q_W-1:0]  z_ff, height_ff;
   logic                   zsat_ff, sat_ff, rsp_valid_ff;

   logic                   xs_done, ys_done, xd_done, yd_done;
   logic [PT_IDX_W-1:0]    xs_idx, ys_idx;
   logic signed [Q_W-1:0]  xs_corner, ys_corner;
   logic signed [S_W-1:0]  xd_quot, yd_quot;
   logic                   query_go, div_go;

   logic signed [Q_W-1:0]  ht_mem [HT_DEPTH];
   logic signed [Q_W-1:0]  ht_rd_ff;
   logic [HT_ADDR_W-1:0]   ht_addr;

   localparam int AW = HT_ADDR_W + PT_IDX_W + CNT_W + 2;
   logic signed [PT_IDX_W+2:0] row_raw, col_raw;
   logic [PT_IDX_W-1:0]    row_c, col_c;
   logic [AW-1:0]          addr_full;

   logic signed [S_W-1:0]  sv;
   logic signed [S2_W-1:0] s2_c;
   logic signed [S3_W-1:0] s3_c;
   logic signed [W_W-1:0]  se, s2e, s3e;
   logic signed [W_W-1:0]  wa, wb, wc, wd, weight_c;
   logic signed [P_W-1:0]  p_c;
   logic signed [Q_W:0]    opnd;
   logic signed [ACC_W-1:0] acc_in, res_c;
   logic                   res_ovf;

   assign q_pop    = (state_ff == ST_IDLE) && q_valid;
   assign query_go = q_pop && (q_item.op == OP_QUERY);
   assign div_go   = (state_ff == ST_SRCH) && xs_fin_ff && ys_fin_ff;

   crgh_search u_xs (
      .clock(clock), .reset(reset),
      .wr_en(q_pop && (q_item.op == OP_WR_X) && !q_item.drop),
      .wr_addr(q_item.index[PT_IDX_W-1:0]), .wr_data(q_item.value),
      .start(query_go), .count(cfg.xn), .key(qx_ff),
      .done(xs_done), .idx(xs_idx), .corner(xs_corner)
   );

   crgh_search u_ys (
      .clock(clock), .reset(reset),
      .wr_en(q_pop && (q_item.op == OP_WR_Y) && !q_item.drop),
      .wr_addr(q_item.index[PT_IDX_W-1:0]), .wr_data(q_item.value),
      .start(query_go), .count(cfg.yn), .key(qy_ff),
      .done(ys_done), .idx(ys_idx), .corner(ys_corner)
   );

   crgh_div u_xd (
      .clock(clock), .reset(reset), .start(div_go),
      .offset(OFF_W'(qx_ff) - OFF_W'(xs_corner)), .spacing(cfg.x_spacing),
      .done(xd_done), .quot(xd_quot)
   );

   crgh_div u_yd (
      .clock(clock), .reset(reset), .start(div_go),
      .offset(OFF_W'(qy_ff) - OFF_W'(ys_corner)), .spacing(cfg.y_spacing),
      .done(yd_done), .quot(yd_quot)
   );

   always_comb begin
      row_raw = signed'({3'b000, ys_idx}) + signed'({{PT_IDX_W{1'b0}}, 1'b0, iy_ff})
                - signed'((PT_IDX_W+3)'(1));
      col_raw = signed'({3'b000, xs_idx}) + signed'({{PT_IDX_W{1'b0}}, 1'b0, ix_ff})
                - signed'((PT_IDX_W+3)'(1));
      if (row_raw < 0) row_c = '0;
      else if (row_raw > signed'({2'b00, cfg.yn - CNT_W'(1)})) row_c = PT_IDX_W'(cfg.yn - CNT_W'(1));
      else row_c = row_raw[PT_IDX_W-1:0];
      if (col_raw < 0) col_c = '0;
      else if (col_raw > signed'({2'b00, cfg.xn - CNT_W'(1)})) col_c = PT_IDX_W'(cfg.xn - CNT_W'(1));
      else col_c = col_raw[PT_IDX_W-1:0];
      addr_full = AW'(row_c) * AW'(cfg.xn) + AW'(col_c);
      ht_addr   = addr_full[HT_ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (q_pop && (q_item.op == OP_WR_H)) ht_mem[q_item.index] <= q_item.value;
      if (state_ff == ST_RD) ht_rd_ff <= ht_mem[ht_addr];
   end

   always_comb begin
      sv   = axis_ff ? t_ff : s_ff;
      s2_c = S2_W'((wm_ff + WM_W'(ONE_Q16 / 2)) >>> FRAC_W);
      s3_c = S3_W'((wm_ff + WM_W'(ONE_Q16 / 2)) >>> FRAC_W);
      se   = W_W'(sv);
      s2e  = W_W'(s2_ff);
      s3e  = W_W'(s3_c);
      wa   = -se + (s2e <<< 1) - s3e;
      wb   = W_W'(2 * ONE_Q16) - ((s2e <<< 2) + s2e) + ((s3e <<< 1) + s3e);
      wc   = se + (s2e <<< 2) - ((s3e <<< 1) + s3e);
      wd   = s3e - s2e;
      weight_c = w_ff[pass_ff][ix_ff];
      p_c  = pass_ff ? rows_ff[ix_ff] : P_W'(ht_rd_ff);
      opnd = (state_ff == ST_MLO) ? signed'({1'b0, p_c[Q_W-1:0]})
                                  : (Q_W+1)'(signed'(p_c[P_W-1:Q_W]));
      acc_in  = acc_ff + (ACC_W'(prod_ff) <<< Q_W);
      res_c   = (acc_in + ACC_W'(ONE_Q16)) >>> (FRAC_W + 1);
      res_ovf = !((&res_c[ACC_W-1:Q_W-1]) || !(|res_c[ACC_W-1:Q_W-1]));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         xs_fin_ff    <= 1'b0;
         ys_fin_ff    <= 1'b0;
         xd_fin_ff    <= 1'b0;
         yd_fin_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp.ready) rsp_valid_ff <= 1'b0;
         if (xs_done) xs_fin_ff <= 1'b1;
         if (ys_done) ys_fin_ff <= 1'b1;
         if (xd_done) begin
            xd_fin_ff <= 1'b1;
            s_ff      <= xd_quot;
         end
         if (yd_done) begin
            yd_fin_ff <= 1'b1;
            t_ff      <= yd_quot;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (query_go) begin
                  qx_ff     <= q_item.qx;
                  qy_ff     <= q_item.qy;
                  xs_fin_ff <= 1'b0;
                  ys_fin_ff <= 1'b0;
                  state_ff  <= ST_SRCH;
               end
            end
            ST_SRCH: begin
               if (div_go) begin
                  xd_fin_ff <= 1'b0;
                  yd_fin_ff <= 1'b0;
                  state_ff  <= ST_DIV;
               end
            end
            ST_DIV: begin
               if (xd_fin_ff && yd_fin_ff) begin
                  axis_ff  <= 1'b0;
                  state_ff <= ST_WSQ;
               end
            end
            ST_WSQ: begin
               wm_ff    <= WM_W'(sv * sv);
               state_ff <= ST_WCU;
            end
            ST_WCU: begin
               s2_ff    <= s2_c;
               wm_ff    <= WM_W'(s2_c * sv);
               state_ff <= ST_WFIN;
            end
            ST_WFIN: begin
               w_ff[axis_ff][0] <= wa;
               w_ff[axis_ff][1] <= wb;
               w_ff[axis_ff][2] <= wc;
               w_ff[axis_ff][3] <= wd;
               if (!axis_ff) begin
                  axis_ff  <= 1'b1;
                  state_ff <= ST_WSQ;
               end else begin
                  pass_ff  <= 1'b0;
                  ix_ff    <= 2'd0;
                  iy_ff    <= 2'd0;
                  acc_ff   <= '0;
                  state_ff <= ST_RD;
               end
            end
            ST_RD: begin
               state_ff <= ST_MLO;
            end
            ST_MLO: begin
               prod_ff  <= weight_c * opnd;
               state_ff <= ST_MHI;
            end
            ST_MHI: begin
               prod_ff  <= weight_c * opnd;
               acc_ff   <= acc_ff + ACC_W'(prod_ff);
               state_ff <= ST_ACC;
            end
            ST_ACC: begin
               if (ix_ff != 2'd3) begin
                  ix_ff    <= ix_ff + 2'd1;
                  acc_ff   <= acc_in;
                  state_ff <= ST_RD;
               end else if (!pass_ff) begin
                  rows_ff[iy_ff] <= res_c[P_W-1:0];
                  ix_ff  <= 2'd0;
                  acc_ff <= '0;
                  if (iy_ff == 2'd3) pass_ff <= 1'b1;
                  else iy_ff <= iy_ff + 2'd1;
                  state_ff <= ST_RD;
               end else begin
                  zsat_ff  <= res_ovf;
                  z_ff     <= res_ovf ? {res_c[ACC_W-1], {(Q_W-1){!res_c[ACC_W-1]}}}
                                      : res_c[Q_W-1:0];
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (!rsp_valid_ff || rsp.ready) begin
                  rsp_valid_ff <= 1'b1;
                  height_ff    <= z_ff;
                  sat_ff       <= zsat_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp.valid     = rsp_valid_ff;
   assign rsp.height    = height_ff;
   assign rsp.saturated = sat_ff;

`ifndef SYNTHESIS
   a_xidx_in_range: assert property (@(posedge clock) disable iff (reset)
      xs_done |=> xs_idx <= PT_IDX_W'(cfg.xn - CNT_W'(1)))
      else $error("x cell index beyond grid");
   a_yidx_in_range: assert property (@(posedge clock) disable iff (reset)
      ys_done |=> ys_idx <= PT_IDX_W'(cfg.yn - CNT_W'(1)))
      else $error("y cell index beyond grid");
   a_param_limited: assert property (@(posedge clock) disable iff (reset)
      xd_done |-> (xd_quot <= S_W'(S_LIMIT)) && (xd_quot >= -S_W'(S_LIMIT)))
      else $error("spline parameter outside limit");
   a_out_hold: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_OUT) && rsp_valid_ff && !rsp.ready |=> state_ff == ST_OUT)
      else $error("result register overwritten while stalled");
`endif
endmodule

// ===== hdl/catmull_rom_grid_height_lookup_unit.sv =====
// Catmull-Rom grid height lookup: top level with the CSR block.
// Depends on crgh_pkg, crgh_if, crgh_front and crgh_back.
//
// Usage:
//  req: one beat per table write (op 0/1/2) or query (op 3). Writes give no
//       response; each query gives exactly one rsp beat (height, saturated).
//  Beats enter a two-entry queue, so up to two beats are taken while the back end
//  works or while a finished result waits on rsp.
//  A write is done as it leaves the queue and does not hold up the back end. A
//  query, once it leaves the queue, runs two parallel binary searches, two
//  parallel 18-step dividers, the weight arithmetic (square, cube, weights) for
//  each axis and twenty spline taps on one shared 26x33 multiplier before its
//  rsp beat.
//  Queries are therefore handled one at a time; the next query leaves the queue
//  only after the previous result has been loaded for rsp.
//  CSR: x_count 0x0, y_count 0x4, x_spacing 0x8, y_spacing 0xC; write only
//  while no query is in flight.
//  Reset: counts return to 2, spacings to 1.0, queue and result empty; table
//  contents are undefined until written.
//  A stalled rsp holds its beat; the back end then waits with the next result.
module catmull_rom_grid_height_lookup_unit import crgh_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   crgh_req_if.sink          req,
   crgh_rsp_if.source        rsp,
   input  logic              csr_psel,
   input  logic              csr_penable,
   input  logic              csr_pwrite,
   input  logic [ADDR_W-1:0] csr_paddr,
   input  logic [31:0]       csr_pwdata,
   output logic [31:0]       csr_prdata,
   output logic              csr_pready
);
   logic [6:0]      x_count_ff, y_count_ff;
   logic [SP_W-1:0] x_spacing_ff, y_spacing_ff;
   logic            csr_wr;
   cfg_type         cfg;
   item_type        q_item;
   logic            q_valid, q_pop;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_ff @(posedge clock) begin
      if (reset) begin
         x_count_ff   <= 7'd2;
         y_count_ff   <= 7'd2;
         x_spacing_ff <= SP_W'(ONE_Q16);
         y_spacing_ff <= SP_W'(ONE_Q16);
      end else if (csr_wr) begin
         unique case (csr_paddr[3:2])
            REG_X_COUNT:   x_count_ff   <= csr_pwdata[6:0];
            REG_Y_COUNT:   y_count_ff   <= csr_pwdata[6:0];
            REG_X_SPACING: x_spacing_ff <= csr_pwdata[SP_W-1:0];
            REG_Y_SPACING: y_spacing_ff <= csr_pwdata[SP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[3:2])
         REG_X_COUNT:   csr_prdata = {25'd0, x_count_ff};
         REG_Y_COUNT:   csr_prdata = {25'd0, y_count_ff};
         REG_X_SPACING: csr_prdata = {1'b0, x_spacing_ff};
         REG_Y_SPACING: csr_prdata = {1'b0, y_spacing_ff};
         default:       csr_prdata = '0;
      endcase
   end

   always_comb begin
      cfg.xn        = eff_count(x_count_ff, MAX_X_POINTS);
      cfg.yn        = eff_count(y_count_ff, MAX_Y_POINTS);
      cfg.x_spacing = (x_spacing_ff == '0) ? SP_W'(1) : x_spacing_ff;
      cfg.y_spacing = (y_spacing_ff == '0) ? SP_W'(1) : y_spacing_ff;
   end

   crgh_front u_front (
      .clock(clock), .reset(reset), .req(req),
      .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop)
   );

   crgh_back u_back (
      .clock(clock), .reset(reset), .cfg(cfg),
      .q_item(q_item), .q_valid(q_valid), .q_pop(q_pop), .rsp(rsp)
   );
endmodule
